// ----- sv/pbce_pkg.sv -----
// Shared types, constants and helpers of the piecewise Bezier curve evaluator.
package pbce_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int SEG_WORDS    = 42;
  localparam int COMPONENTS   = 10;
  localparam int VALUE_WIDTH  = 32;
  localparam int TABLE_WORDS  = MAX_SEGMENTS * SEG_WORDS;
  localparam int ADDR_W       = $clog2(TABLE_WORDS);
  localparam int SLOT_W       = 8;
  localparam int WORD_W       = 6;
  localparam int COUNT_W      = 9;
  localparam int FRAC_W       = 16;
  localparam int IN_DATA_W    = 80;
  localparam int OUT_DATA_W   = SLOT_W + COMPONENTS * VALUE_WIDTH;

  localparam logic [WORD_W-1:0] W_START  = 6'd0;
  localparam logic [WORD_W-1:0] W_END    = 6'd1;
  localparam logic [WORD_W-1:0] W_POINTS = 6'd2;

  localparam logic [4:0] DIV_LAST   = 5'd16;
  localparam logic [4:0] PT_LAST    = 5'd4;
  localparam logic [2:0] BLEND_LAST = 3'd5;
  localparam logic [3:0] COMP_LAST  = 4'(COMPONENTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_S_RD, ST_S_CMP, ST_E_RD0, ST_E_RD1, ST_E_CHK,
    ST_DIV, ST_P_RD, ST_BL_MUL, ST_BL_ADD, ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {RD_MID, RD_START, RD_END, RD_POINT} rd_sel_t;

  typedef struct packed {
    logic       load_we;
    logic       search_init;
    logic       search_upd;
    rd_sel_t    rd_sel;
    logic       start_latch;
    logic       div_init;
    logic       div_step;
    logic       div_first;
    logic [1:0] pt;
    logic [3:0] comp;
    logic       p_load;
    logic [1:0] p_idx;
    logic       bl_mul;
    logic       bl_add;
    logic [1:0] bj;
    logic       comp_we;
    logic       out_load;
    logic       out_found;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic span_gt1;
    logic in_range;
    logic out_busy;
  } dp_stat_t;

  // Word address of the first word of a segment.
  function automatic logic [ADDR_W-1:0] seg_base(input logic [SLOT_W-1:0] seg);
    seg_base = ADDR_W'(seg) * ADDR_W'(SEG_WORDS);
  endfunction

  // Lower operand slot of each de Casteljau step, done in place.
  function automatic logic [1:0] blend_target(input logic [2:0] step);
    case (step)
      3'd1:    blend_target = 2'd1;
      3'd2:    blend_target = 2'd2;
      3'd4:    blend_target = 2'd1;
      default: blend_target = 2'd0;
    endcase
  endfunction

endpackage

// ----- sv/pbce_datapath.sv -----
// Datapath: segment memory, search registers, serial divider and blend unit.
module pbce_datapath import pbce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [COUNT_W-1:0]    cfg_data,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  dp_cmd_t               cmd,
  input  logic                  m_tready,
  output dp_stat_t              stat,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  logic [VALUE_WIDTH-1:0] mem [TABLE_WORDS];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [ADDR_W-1:0]      raddr;
  logic [ADDR_W-1:0]      waddr;

  logic [SLOT_W-1:0]       in_seg;
  logic [WORD_W-1:0]       in_word;
  logic [VALUE_WIDTH-1:0]  in_value;
  logic [VALUE_WIDTH-1:0]  in_param;

  logic [COUNT_W-1:0]      seg_count;
  logic [COUNT_W-1:0]      n_eff;
  logic [SLOT_W-1:0]       lo;
  logic [COUNT_W-1:0]      hi;
  logic [SLOT_W-1:0]       mid;
  logic signed [31:0]      param;
  logic signed [31:0]      start;
  logic signed [31:0]      rd_s;

  logic [32:0]             rem;
  logic [31:0]             den;
  logic                    den_zero;
  logic [16:0]             quo;
  logic [16:0]             t;
  logic [33:0]             rr;
  logic                    ge;
  logic signed [32:0]      num_diff;

  logic signed [31:0]      p [4];
  logic signed [31:0]      a_hold;
  logic signed [50:0]      prod;
  logic signed [32:0]      bdiff;
  logic signed [50:0]      rounded;
  logic signed [31:0]      bres;
  logic signed [31:0]      comp [COMPONENTS];
  logic [OUT_DATA_W-1:0]   out_word;

  assign in_seg   = s_tdata[7:0];
  assign in_word  = s_tdata[13:8];
  assign in_value = s_tdata[45:14];
  assign in_param = s_tdata[77:46];

  assign n_eff = (seg_count > COUNT_W'(MAX_SEGMENTS)) ? COUNT_W'(MAX_SEGMENTS) : seg_count;
  assign mid   = SLOT_W'((10'(lo) + 10'(hi)) >> 1);
  assign rd_s  = $signed(rdata);
  assign waddr = seg_base(in_seg) + ADDR_W'(in_word);

  always_comb begin
    case (cmd.rd_sel)
      RD_START: raddr = seg_base(lo) + ADDR_W'(W_START);
      RD_END:   raddr = seg_base(lo) + ADDR_W'(W_END);
      RD_POINT: raddr = seg_base(lo) + ADDR_W'(W_POINTS)
                        + ADDR_W'(cmd.pt) * ADDR_W'(COMPONENTS) + ADDR_W'(cmd.comp);
      default:  raddr = seg_base(mid) + ADDR_W'(W_START);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we && (in_word < WORD_W'(SEG_WORDS))) begin
      mem[waddr] <= in_value;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
    end else if (cfg_we) begin
      seg_count <= cfg_data;
    end
  end

  // Binary search over segment start times.
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo    <= '0;
      hi    <= n_eff;
      param <= $signed(in_param);
    end else if (cmd.search_upd) begin
      if (param >= rd_s) begin
        lo <= mid;
      end else begin
        hi <= COUNT_W'(mid);
      end
    end
    if (cmd.start_latch) begin
      start <= rd_s;
    end
  end

  // Restoring division giving the 17-bit fraction (param-start)/(end-start).
  assign num_diff = {param[31], param} - {start[31], start};
  assign rr       = cmd.div_first ? {1'b0, rem} : {rem, 1'b0};
  assign ge       = (rr >= {2'b00, den});
  assign t        = den_zero ? '0 : quo;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem      <= 33'(num_diff);
      den      <= 32'({rd_s[31], rd_s} - {start[31], start});
      den_zero <= (rd_s == start);
      quo      <= '0;
    end else if (cmd.div_step) begin
      rem <= 33'(ge ? (rr - {2'b00, den}) : rr);
      quo <= {quo[15:0], ge};
    end
  end

  // One blend: a + round((b - a) * t / 2^16), multiply then add.
  assign bdiff   = {p[2'(cmd.bj + 2'd1)][31], p[2'(cmd.bj + 2'd1)]}
                   - {p[cmd.bj][31], p[cmd.bj]};
  assign rounded = (prod + 51'sd32768) >>> FRAC_W;
  assign bres    = a_hold + rounded[31:0];

  always_ff @(posedge clk) begin
    if (cmd.p_load) begin
      p[cmd.p_idx] <= rd_s;
    end else if (cmd.bl_add) begin
      p[cmd.bj] <= bres;
    end
    if (cmd.bl_mul) begin
      prod   <= 51'(bdiff * $signed({1'b0, t}));
      a_hold <= p[cmd.bj];
    end
    if (cmd.comp_we) begin
      comp[cmd.comp] <= bres;
    end
  end

  always_comb begin
    out_word = '0;
    out_word[SLOT_W-1:0] = lo;
    for (int k = 0; k < COMPONENTS; k++) begin
      out_word[SLOT_W + VALUE_WIDTH*k +: VALUE_WIDTH] =
        cmd.out_found ? comp[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= out_word;
      m_tuser <= cmd.out_found;
    end
  end

  assign stat.n_zero   = (n_eff == '0);
  assign stat.span_gt1 = (COUNT_W'(hi - COUNT_W'(lo)) > COUNT_W'(1));
  assign stat.in_range = (param >= start) && (param <= rd_s);
  assign stat.out_busy = m_tvalid;

endmodule

// ----- sv/pbce_ctrl.sv -----
// Controller: sequences search, range check, division and interpolation.
module pbce_ctrl import pbce_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  logic     s_tuser,
  output logic     s_tready,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic [4:0]  cnt;
  logic [3:0]  comp_k;
  logic [2:0]  bstep;
  logic        found;
  logic        acc;

  assign acc = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (acc && s_tuser) state_next = stat.n_zero ? ST_DONE : ST_S_RD;
      ST_S_RD:   state_next = stat.span_gt1 ? ST_S_CMP : ST_E_RD0;
      ST_S_CMP:  state_next = ST_S_RD;
      ST_E_RD0:  state_next = ST_E_RD1;
      ST_E_RD1:  state_next = ST_E_CHK;
      ST_E_CHK:  state_next = stat.in_range ? ST_DIV : ST_DONE;
      ST_DIV:    if (cnt == DIV_LAST) state_next = ST_P_RD;
      ST_P_RD:   if (cnt == PT_LAST) state_next = ST_BL_MUL;
      ST_BL_MUL: state_next = ST_BL_ADD;
      ST_BL_ADD: begin
        if (bstep == BLEND_LAST) begin
          state_next = (comp_k == COMP_LAST) ? ST_DONE : ST_P_RD;
        end else begin
          state_next = ST_BL_MUL;
        end
      end
      ST_DONE:   if (!stat.out_busy || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_MID;
    cmd.pt       = cnt[1:0];
    cmd.comp     = comp_k;
    cmd.bj       = blend_target(bstep);
    cmd.p_idx    = 2'(cnt - 5'd1);
    cmd.out_found = found;
    s_tready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // The request side is always ready here, so tvalid alone marks a request.
        s_tready        = 1'b1;
        cmd.load_we     = s_tvalid && !s_tuser;
        cmd.search_init = s_tvalid && s_tuser;
      end
      ST_S_CMP:  cmd.search_upd = 1'b1;
      ST_E_RD0:  cmd.rd_sel = RD_START;
      ST_E_RD1: begin
        cmd.rd_sel      = RD_END;
        cmd.start_latch = 1'b1;
      end
      ST_E_CHK:  cmd.div_init = 1'b1;
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt == '0);
      end
      ST_P_RD: begin
        cmd.rd_sel = RD_POINT;
        cmd.p_load = (cnt != '0);
      end
      ST_BL_MUL: cmd.bl_mul = 1'b1;
      ST_BL_ADD: begin
        cmd.bl_add  = 1'b1;
        cmd.comp_we = (bstep == BLEND_LAST);
      end
      ST_DONE:   cmd.out_load = !stat.out_busy || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      comp_k <= '0;
      bstep  <= '0;
      found  <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= '0;
      end else if (state == ST_DIV || state == ST_P_RD) begin
        cnt <= cnt + 5'd1;
      end
      if (cmd.search_init) begin
        comp_k <= '0;
        bstep  <= '0;
        found  <= 1'b0;
      end
      if (state == ST_E_CHK && stat.in_range) begin
        found <= 1'b1;
      end
      if (state == ST_BL_ADD) begin
        if (bstep == BLEND_LAST) begin
          bstep  <= '0;
          comp_k <= comp_k + 4'd1;
        end else begin
          bstep <= bstep + 3'd1;
        end
      end
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(stat.out_busy && !m_tready))
    else $error("result register overwritten while still held");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt <= DIV_LAST))
    else $error("division ran past its last quotient bit");
  a_comp_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BL_ADD) |-> (comp_k <= COMP_LAST && bstep <= BLEND_LAST))
    else $error("interpolation counters out of range");
  a_found_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> found)
    else $error("division started for a parameter outside its segment");

endmodule

// ----- sv/piecewise_bezier_curve_evaluator.sv -----
// Top level of the piecewise cubic Bezier curve evaluator.
//
//   channel  | direction | contents
//   ---------+-----------+--------------------------------------------------
//   cfg      | in        | segment_count write (cfg_we, cfg_data)
//   s_*      | in        | request: load one segment word or query a parameter
//   m_*      | out       | query result: found flag, segment index, ten values
//
// A load request is written to the segment memory in the cycle it is
// accepted; it gives no result. A query runs a binary search (at most 8
// steps), a start/end check, the serial divider and then a blend of each of
// the ten components in turn, since the segment memory has one read port and
// the one blend multiplier is shared; no new request is taken until the query
// is done. A parameter outside its segment finishes after the check.
// Reset (rst, synchronous) clears the segment count and all control state; the
// segment memory holds no defined value until written.
// A finished result waits in the output register while a new request is taken;
// a query that finishes while the previous result is still held waits for it.
module piecewise_bezier_curve_evaluator import pbce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [COUNT_W-1:0]    cfg_data,   // segment_count
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // segment_slot, word_slot, word_value, query_param, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,    // req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // segment_index, center_x/y/z, log_size, forward_x/y/z, up_x/y/z
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser     // found
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller only decides the sequence; all arithmetic and storage
  // lives in the datapath.
  pbce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbce_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .m_tready (m_tready),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the piecewise Bezier curve evaluator.
`timescale 1ns / 1ps

module tb import pbce_pkg::*; ();

  // Kinds of rows in the directed table.
  typedef enum int {K_LOAD, K_QUERY, K_COUNT} row_kind_t;

  // One evaluated point of the curve as the block returns it.
  typedef struct packed {
    logic                             found;
    logic [7:0]                       idx;
    logic [COMPONENTS-1:0][31:0]      comp;
  } curve_point_t;

  // Directed row. Where chk is set the expected point is typed in: components
  // are base + c*step for component c.
  typedef struct {
    row_kind_t   kind;
    int          seg;
    int          word;
    logic [31:0] val;
    logic [31:0] param;
    bit          chk;
    bit          found;
    int          idx;
    logic [31:0] base;
    logic [31:0] step;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [COUNT_W-1:0]    cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  piecewise_bezier_curve_evaluator u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the segment table and of the segment count.
  logic [31:0]  shadow_words [MAX_SEGMENTS][SEG_WORDS];
  int           shadow_count;

  curve_point_t pending_points [$];
  int           mismatches;
  int           n_queries;
  int           n_found;
  int           n_loads;
  int           n_results;
  int           rx_hold_cycles;   // long output stall requested by the sender side
  bit           tx_steady;        // sender offers requests back to back
  string        comp_name [COMPONENTS] = '{"center_x", "center_y", "center_z", "log_size",
    "forward_x", "forward_y", "forward_z", "up_x", "up_y", "up_z"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, well above the slowest legal run.
  initial begin
    #30_000_000;
    $display("** piecewise_bezier_curve_evaluator: FAILED **");
    $finish;
  end

  // Start time of segment k in the base table: one unit apart from -128.0 up.
  function automatic logic [31:0] base_start(input int k);
    base_start = 32'((k - 128) * 65536);
  endfunction

  // One linear step of de Casteljau with round half up; >>> floors the sum.
  function automatic longint lerp_q16(input longint a, input longint b, input longint t);
    longint s;
    s = a * (65536 - t) + b * t + 32768;
    lerp_q16 = s >>> 16;
  endfunction

  // Searches the shadow table and evaluates the curve at param.
  function automatic curve_point_t eval_curve(input logic [31:0] param);
    curve_point_t pt;
    int           n, lo, hi, mid, k, j;
    longint       p, st, en, t;
    longint       cp [4];
    longint       q0, q1, q2, r0, r1;
    pt = '0;
    n  = (shadow_count > MAX_SEGMENTS) ? MAX_SEGMENTS : shadow_count;
    if (n == 0) return pt;
    p  = longint'($signed(param));
    lo = 0;
    hi = n;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (p >= longint'($signed(shadow_words[mid][W_START]))) lo = mid;
      else hi = mid;
    end
    pt.idx = 8'(lo);
    st = longint'($signed(shadow_words[lo][W_START]));
    en = longint'($signed(shadow_words[lo][W_END]));
    if (p < st || p > en) return pt;
    t = (en == st) ? 0 : ((p - st) * 65536) / (en - st);
    pt.found = 1'b1;
    for (k = 0; k < COMPONENTS; k++) begin
      for (j = 0; j < 4; j++)
        cp[j] = longint'($signed(shadow_words[lo][W_POINTS + j * COMPONENTS + k]));
      q0 = lerp_q16(cp[0], cp[1], t);
      q1 = lerp_q16(cp[1], cp[2], t);
      q2 = lerp_q16(cp[2], cp[3], t);
      r0 = lerp_q16(q0, q1, t);
      r1 = lerp_q16(q1, q2, t);
      pt.comp[k] = 32'(lerp_q16(r0, r1, t));
    end
    return pt;
  endfunction

  // Offers one request after a random gap, none while tx_steady, and waits for
  // its acceptance. A query queues either the typed expectation or the predicted point.
  task automatic send(input logic is_query, input int seg, input int word,
                      input logic [31:0] val, input logic [31:0] param,
                      input bit use_typed, input curve_point_t typed);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= is_query;
    s_tdata  <= {2'b00, param, val, 6'(word), 8'(seg)};
    do @(posedge clk); while (!s_tready);
    if (is_query) begin
      n_queries++;
      pending_points.insert(pending_points.size(), use_typed ? typed : eval_curve(param));
    end else begin
      n_loads++;
      if (seg < MAX_SEGMENTS && word < SEG_WORDS) shadow_words[seg][word] = val;
    end
  endtask

  task automatic load_word(input int seg, input int word, input logic [31:0] val);
    send(1'b0, seg, word, val, '0, 1'b0, '0);
  endtask

  task automatic query(input logic [31:0] param);
    send(1'b1, 0, 0, '0, param, 1'b0, '0);
  endtask

  // Stops offering and waits until every queued result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The segment count may only change while the block is idle.
  task automatic set_count(input int n);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= COUNT_W'(n);
    @(posedge clk);
    cfg_we   <= 1'b0;
    shadow_count = n;
  endtask

  // Result side: checks each result against the oldest expectation and
  // draws its own stalls, with a long hold-off on request.
  initial begin
    curve_point_t want;
    int           gap;
    bit           steady;
    m_tready = 1'b0;
    gap      = 0;
    steady   = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        n_results++;
        if (n_results % 100 == 0) steady = ~steady;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (pending_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: found=%0b index=%0d",
                                         m_tuser, m_tdata[7:0]);
        end else begin
          want = pending_points.pop_front();
          if (want.found) n_found++;
          if (m_tuser !== want.found) begin
            mismatches++;
            if (mismatches <= 10) $display("result %0d found: expected %0b, got %0b",
                                           n_results, want.found, m_tuser);
          end
          if (m_tdata[7:0] !== want.idx) begin
            mismatches++;
            if (mismatches <= 10) $display("result %0d segment_index: expected %0d, got %0d",
                                           n_results, want.idx, m_tdata[7:0]);
          end
          for (int k = 0; k < COMPONENTS; k++)
            if (m_tdata[8 + 32 * k +: 32] !== want.comp[k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("result %0d %s: expected %h, got %h", n_results, comp_name[k],
                         want.comp[k], m_tdata[8 + 32 * k +: 32]);
            end
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus: table build, directed rows, then random phases.
  initial begin
    row_t         rows [25];
    curve_point_t typed;
    logic [31:0]  v, p;
    int           items, phase, n, k, r, span;

    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = 1'b0;
    mismatches     = 0;
    n_queries      = 0;
    n_found        = 0;
    n_loads        = 0;
    n_results      = 0;
    rx_hold_cycles = 0;
    tx_steady      = 1'b0;
    shadow_count   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Start and end of every segment. Segments 0..7 hold data; segment 3 has
    // zero length and segment 7 reaches the top of the range. Segments above
    // end before they start, so a query can never read their points.
    for (k = 0; k < MAX_SEGMENTS; k++) begin
      load_word(k, W_START, base_start(k));
      if (k == 3)     v = base_start(k);
      else if (k == 7) v = 32'h7fff_ffff;
      else if (k < 7)  v = base_start(k) + 32'h8000;
      else             v = base_start(k) - 1;
      load_word(k, W_END, v);
    end
    // Segment 0 holds a ramp, segments 1 and 2 the two extremes, the rest random.
    for (k = 0; k < 8; k++)
      for (int w = W_POINTS; w < SEG_WORDS; w++) begin
        case (k)
          0:       v = 32'((w - W_POINTS) * 65536);
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h8000_0000;
          default: v = $urandom;
        endcase
        load_word(k, w, v);
      end

    rows[0]  = '{K_QUERY, 0, 0, 0, 32'h0, 1, 0, 0, 0, 0};
    rows[1]  = '{K_QUERY, 0, 0, 0, 32'h7fff_ffff, 1, 0, 0, 0, 0};
    rows[2]  = '{K_QUERY, 0, 0, 0, 32'h8000_0000, 1, 0, 0, 0, 0};
    rows[3]  = '{K_LOAD, 255, 63, 32'hffff_ffff, 0, 0, 0, 0, 0, 0};
    rows[4]  = '{K_LOAD, 0, 42, 32'h0001_2345, 0, 0, 0, 0, 0, 0};
    rows[5]  = '{K_COUNT, 1, 0, 0, 0, 0, 0, 0, 0, 0};
    rows[6]  = '{K_QUERY, 0, 0, 0, base_start(0), 1, 1, 0, 0, 32'h1_0000};
    rows[7]  = '{K_QUERY, 0, 0, 0, base_start(0) + 32'h8000, 1, 1, 0, 32'h1e_0000, 32'h1_0000};
    rows[8]  = '{K_QUERY, 0, 0, 0, base_start(0) - 1, 1, 0, 0, 0, 0};
    rows[9]  = '{K_QUERY, 0, 0, 0, base_start(0) + 32'h8001, 1, 0, 0, 0, 0};
    rows[10] = '{K_QUERY, 0, 0, 0, base_start(0) + 32'h4000, 0, 0, 0, 0, 0};
    rows[11] = '{K_COUNT, 8, 0, 0, 0, 0, 0, 0, 0, 0};
    rows[12] = '{K_QUERY, 0, 0, 0, base_start(1), 1, 1, 1, 32'h7fff_ffff, 0};
    rows[13] = '{K_QUERY, 0, 0, 0, base_start(2) + 32'h3000, 1, 1, 2, 32'h8000_0000, 0};
    rows[14] = '{K_QUERY, 0, 0, 0, base_start(3), 0, 0, 0, 0, 0};
    rows[15] = '{K_QUERY, 0, 0, 0, base_start(3) + 1, 1, 0, 3, 0, 0};
    rows[16] = '{K_QUERY, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0, 0};
    rows[17] = '{K_QUERY, 0, 0, 0, 32'h8000_0000, 1, 0, 0, 0, 0};
    rows[18] = '{K_COUNT, 256, 0, 0, 0, 0, 0, 0, 0, 0};
    rows[19] = '{K_QUERY, 0, 0, 0, 32'h7fff_ffff, 1, 0, 255, 0, 0};
    rows[20] = '{K_QUERY, 0, 0, 0, base_start(200), 1, 0, 200, 0, 0};
    rows[21] = '{K_COUNT, 511, 0, 0, 0, 0, 0, 0, 0, 0};
    rows[22] = '{K_QUERY, 0, 0, 0, base_start(255), 1, 0, 255, 0, 0};
    rows[23] = '{K_QUERY, 0, 0, 0, base_start(5) + 32'h100, 0, 0, 0, 0, 0};
    rows[24] = '{K_COUNT, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    foreach (rows[i]) begin
      case (rows[i].kind)
        K_LOAD:  load_word(rows[i].seg, rows[i].word, rows[i].val);
        K_COUNT: set_count(rows[i].seg);
        default: begin
          typed.found = rows[i].found;
          typed.idx   = 8'(rows[i].idx);
          for (int c = 0; c < COMPONENTS; c++)
            typed.comp[c] = rows[i].base + 32'(c) * rows[i].step;
          send(1'b1, 0, 0, '0, rows[i].param, rows[i].chk, typed);
        end
      endcase
    end

    // Random phases: mostly queries near the populated segments, with point
    // and end rewrites and some loads outside the table.
    items = n_loads + n_queries;
    phase = 0;
    while (items < 1650) begin
      phase++;
      case (phase % 6)
        0:       n = $urandom_range(1, 8);
        1:       n = 8;
        2:       n = 256;
        3:       n = 511;
        4:       n = $urandom_range(9, 511);
        default: n = $urandom_range(0, 8);
      endcase
      set_count(n);
      tx_steady = (phase % 4 == 1);
      // Once, hold the result side for a long time while requests keep coming.
      if (phase == 3) rx_hold_cycles = 800;
      repeat (60) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          k = (n > 8 && $urandom_range(0, 4) == 0) ?
              $urandom_range(8, (n > MAX_SEGMENTS ? MAX_SEGMENTS : n) - 1) :
              $urandom_range(0, 7);
          p = base_start(k) + $urandom_range(0, 32'h8200) - 32'h100;
          if ($urandom_range(0, 9) == 0) p = $urandom;
          query(p);
          items++;
        end else if (r < 85) begin
          case ($urandom_range(0, 9))
            0:       v = 32'h7fff_ffff;
            1:       v = 32'h8000_0000;
            default: v = $urandom;
          endcase
          load_word($urandom_range(0, 7), $urandom_range(W_POINTS, SEG_WORDS - 1), v);
          items++;
        end else if (r < 92) begin
          k = $urandom_range(0, 6);
          span = $urandom_range(0, 32'h9000);
          load_word(k, W_END, base_start(k) + 32'(span));
          items++;
        end else begin
          load_word($urandom_range(0, 255), $urandom_range(SEG_WORDS, 63), $urandom);
          items++;
        end
      end
      // Once, pause the requests until every result is back.
      if (phase == 5) drain();
    end

    drain();
    repeat (400) @(posedge clk);
    $display("Covered %0d queries (%0d inside a segment) and %0d word loads over %0d phases",
             n_queries, n_found, n_loads, phase);
    $display("of segment counts from empty through full capacity and beyond; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_points.size() == 0)
      $display("** piecewise_bezier_curve_evaluator: PASSED **");
    else
      $display("** piecewise_bezier_curve_evaluator: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pbce_pkg.sv
sv/pbce_datapath.sv
sv/pbce_ctrl.sv
sv/piecewise_bezier_curve_evaluator.sv
dv/tb.sv
